### rtl/pcf_pkg.sv
// package: conversion codes, character constants and digit lookup
`timescale 1ns / 1ps
`default_nettype none

package pcf_pkg;

  // conversion codes (ascii)
  localparam logic [7:0] CODE_D       = 8'h64;  // d
  localparam logic [7:0] CODE_I       = 8'h69;  // i
  localparam logic [7:0] CODE_U       = 8'h75;  // u
  localparam logic [7:0] CODE_XL      = 8'h78;  // x
  localparam logic [7:0] CODE_XU      = 8'h58;  // X
  localparam logic [7:0] CODE_P       = 8'h70;  // p
  localparam logic [7:0] CODE_C       = 8'h63;  // c
  localparam logic [7:0] CODE_PERCENT = 8'h25;  // %

  // emitted characters
  localparam logic [7:0] CHAR_MINUS   = 8'h2d;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_X       = 8'h78;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;

  // digit count of each number kind
  localparam logic [4:0] DEC_DIGITS = 5'd10;
  localparam logic [4:0] HEX32_DIGITS = 5'd8;
  localparam logic [4:0] HEX64_DIGITS = 5'd16;

  // nibble to ascii digit, decimal digits share the hex table
  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [7:0] ch;
    case (nib)
      4'h0: ch = 8'h30;
      4'h1: ch = 8'h31;
      4'h2: ch = 8'h32;
      4'h3: ch = 8'h33;
      4'h4: ch = 8'h34;
      4'h5: ch = 8'h35;
      4'h6: ch = 8'h36;
      4'h7: ch = 8'h37;
      4'h8: ch = 8'h38;
      4'h9: ch = 8'h39;
      4'ha: ch = upper ? 8'h41 : 8'h61;
      4'hb: ch = upper ? 8'h42 : 8'h62;
      4'hc: ch = upper ? 8'h43 : 8'h63;
      4'hd: ch = upper ? 8'h44 : 8'h64;
      4'he: ch = upper ? 8'h45 : 8'h65;
      4'hf: ch = upper ? 8'h46 : 8'h66;
      default: ch = 8'h30;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

### rtl/pcf_in_if.sv
// interface: conversion request channel
`timescale 1ns / 1ps
`default_nettype none

interface pcf_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  conv_code;
  logic [63:0] arg_value;

  modport source (output valid, output conv_code, output arg_value, input ready);
  modport sink (input valid, input conv_code, input arg_value, output ready);
endinterface

`default_nettype wire

### rtl/pcf_out_if.sv
// interface: formatted character channel
`timescale 1ns / 1ps
`default_nettype none

interface pcf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink (input valid, input out_char, input last_char, output ready);
endinterface

`default_nettype wire

### rtl/printf_conversion_formatter.sv
// top level: printf integer conversion to a stream of ascii characters
`timescale 1ns / 1ps
`default_nettype none

// channel    dir  handshake            payload
// in_chan    in   valid/ready          conv_code[7:0], arg_value[63:0]
// out_chan   out  valid/ready          out_char[7:0], last_char
//
// one conversion at a time; in_chan.ready is high only between conversions
// decimal: accept, bit-serial binary to bcd conversion of the 32-bit value, a
//   minus for a negative value, leading zeros skipped, then the digits
// hex: accept, the 0x prefix for p only, leading zeros skipped, then the
//   digits, at most 8 for x and 16 for p
// c and %: accept, then the one character; unknown codes return to idle at once
// rst_n is synchronous; an out_chan stall holds the output register and
// pauses emission, the next conversion is taken while the final character
// still waits

module printf_conversion_formatter (
  input  wire       clk,
  input  wire       rst_n,
  pcf_in_if.sink    in_chan,
  pcf_out_if.source out_chan
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_PRE,
    ST_SKIP,
    ST_EMIT
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] bin_r, bin_nxt;       // binary value shifting into the bcd digits
  logic [63:0] num_r, num_nxt;       // digit nibbles, most significant at the top
  logic [4:0]  cnt_r, cnt_nxt;       // conversion bit counter
  logic [4:0]  ndig_r, ndig_nxt;     // nibbles left in num_r
  logic [15:0] pre_r, pre_nxt;       // prefix characters, first at the top
  logic [1:0]  pre_n_r, pre_n_nxt;   // prefix characters left
  logic        only_r, only_nxt;     // prefix is the whole conversion
  logic        upper_r, upper_nxt;   // upper case hex letters

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_char_r, out_char_nxt;
  logic        out_last_r, out_last_nxt;

  logic        slot_free;
  logic [31:0] low32;
  logic [31:0] neg32;
  logic [39:0] bcd_adj;              // bcd digits after the add-3 correction

  assign slot_free = !out_valid_r || out_chan.ready;
  assign low32     = in_chan.arg_value[31:0];
  assign neg32     = ~low32 + 32'd1;

  assign in_chan.ready      = (state_r == ST_IDLE);
  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_char  = out_char_r;
  assign out_chan.last_char = out_last_r;

  // double dabble correction: each bcd digit of 5 or more gets 3 added
  always_comb begin
    for (int k = 0; k < 10; k++) begin
      bcd_adj[39 - 4*k -: 4] = (num_r[63 - 4*k -: 4] >= 4'd5) ?
                               num_r[63 - 4*k -: 4] + 4'd3 : num_r[63 - 4*k -: 4];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    num_nxt       = num_r;
    cnt_nxt       = cnt_r;
    ndig_nxt      = ndig_r;
    pre_nxt       = pre_r;
    pre_n_nxt     = pre_n_r;
    only_nxt      = only_r;
    upper_nxt     = upper_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;

    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          cnt_nxt   = 5'd31;
          num_nxt   = '0;
          pre_nxt   = '0;
          pre_n_nxt = 2'd0;
          only_nxt  = 1'b0;
          upper_nxt = 1'b0;
          case (in_chan.conv_code)
            pcf_pkg::CODE_D, pcf_pkg::CODE_I: begin
              // negative values print a minus and the two's complement magnitude
              bin_nxt   = low32[31] ? neg32 : low32;
              pre_nxt   = {pcf_pkg::CHAR_MINUS, 8'h00};
              pre_n_nxt = {1'b0, low32[31]};
              ndig_nxt  = pcf_pkg::DEC_DIGITS;
              state_nxt = ST_CONV;
            end
            pcf_pkg::CODE_U: begin
              bin_nxt   = low32;
              ndig_nxt  = pcf_pkg::DEC_DIGITS;
              state_nxt = ST_CONV;
            end
            pcf_pkg::CODE_XL, pcf_pkg::CODE_XU: begin
              num_nxt   = {low32, 32'h0};
              ndig_nxt  = pcf_pkg::HEX32_DIGITS;
              upper_nxt = (in_chan.conv_code == pcf_pkg::CODE_XU);
              state_nxt = ST_SKIP;
            end
            pcf_pkg::CODE_P: begin
              num_nxt   = in_chan.arg_value;
              ndig_nxt  = pcf_pkg::HEX64_DIGITS;
              pre_nxt   = {pcf_pkg::CHAR_ZERO, pcf_pkg::CHAR_X};
              pre_n_nxt = 2'd2;
              state_nxt = ST_PRE;
            end
            pcf_pkg::CODE_C: begin
              pre_nxt   = {in_chan.arg_value[7:0], 8'h00};
              pre_n_nxt = 2'd1;
              only_nxt  = 1'b1;
              state_nxt = ST_PRE;
            end
            pcf_pkg::CODE_PERCENT: begin
              pre_nxt   = {pcf_pkg::CHAR_PERCENT, 8'h00};
              pre_n_nxt = 2'd1;
              only_nxt  = 1'b1;
              state_nxt = ST_PRE;
            end
            default: begin
              // unknown code: nothing to print
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_CONV: begin
        // one binary bit enters the bcd digits per cycle
        {num_nxt[63:24], bin_nxt} = {bcd_adj[38:0], bin_r, 1'b0};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          state_nxt = (pre_n_r != 2'd0) ? ST_PRE : ST_SKIP;
        end
      end

      ST_PRE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = pre_r[15:8];
          out_last_nxt  = only_r && (pre_n_r == 2'd1);
          pre_nxt       = {pre_r[7:0], 8'h00};
          pre_n_nxt     = pre_n_r - 2'd1;
          if (pre_n_r == 2'd1) begin
            state_nxt = only_r ? ST_IDLE : ST_SKIP;
          end
        end
      end

      ST_SKIP: begin
        // drop leading zero digits, always keep the last one
        if ((num_r[63:60] == 4'h0) && (ndig_r != 5'd1)) begin
          num_nxt  = {num_r[59:0], 4'h0};
          ndig_nxt = ndig_r - 5'd1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = pcf_pkg::digit_char(num_r[63:60], upper_r);
          out_last_nxt  = (ndig_r == 5'd1);
          num_nxt       = {num_r[59:0], 4'h0};
          ndig_nxt      = ndig_r - 5'd1;
          if (ndig_r == 5'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bin_r      <= bin_nxt;
    num_r      <= num_nxt;
    cnt_r      <= cnt_nxt;
    ndig_r     <= ndig_nxt;
    pre_r      <= pre_nxt;
    pre_n_r    <= pre_n_nxt;
    only_r     <= only_nxt;
    upper_r    <= upper_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

`default_nettype wire
